/* hdl/dsst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_pkg: shared types and constants of the sequence tracker
// Sizes, action codes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package dsst_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int SEQ_BITS     = 32;
   localparam int LIMIT_BITS   = 5;
   localparam int ACTION_BITS  = 2;
   localparam int IDX_BITS     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_BITS     = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_ISSUE           = 2'd0,
      ACT_FORCE_COMPLETE  = 2'd1,
      ACT_RECV_COMPLETE   = 2'd2,
      ACT_RECV_COMPRESSED = 2'd3
   } action_type;

   typedef struct packed {
      logic                load;
      logic                exec;
      logic                chain;
      logic                scan;
      logic                resync;
      logic                publish;
      logic [IDX_BITS-1:0] scan_idx;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       room;
      logic       waiting;
      logic       chain_found;
      logic       out_free;
   } sts_type;

   // Saturating increment: hold at all ones.
   function automatic logic [SEQ_BITS-1:0] seq_inc(input logic [SEQ_BITS-1:0] v);
      logic [SEQ_BITS-1:0] r;
      r = (v == {SEQ_BITS{1'b1}}) ? v : v + SEQ_BITS'(1);
      return r;
   endfunction

endpackage

/* hdl/dsst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_ctrl: sequencing controller of the sequence tracker
// Steps one word through execute, chain, scan, resync and publish.
// ----------------------------------------------------------------------------
module dsst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dsst_pkg::sts_type sts,
   output dsst_pkg::cmd_type cmd
);
   import dsst_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_EXEC    = 6'b000010,
      ST_CHAIN   = 6'b000100,
      ST_SCAN    = 6'b001000,
      ST_RESYNC  = 6'b010000,
      ST_PUBLISH = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.scan_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (sts.action)
               ACT_RECV_COMPLETE: state_in = ST_CHAIN;
               ACT_RECV_COMPRESSED: begin
                  if (sts.room || sts.waiting) begin
                     state_in = ST_PUBLISH;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: state_in = ST_PUBLISH;
            endcase
         end
         ST_CHAIN: begin
            cmd.chain = 1'b1;
            if (!sts.chain_found) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_ff == IDX_BITS'(WINDOW_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_RESYNC;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         ST_RESYNC: begin
            cmd.resync = 1'b1;
            state_in   = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

/* hdl/dsst_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_datapath: sender and receiver state of the sequence tracker
// Counters, reorder window, resync point and the result register.
// ----------------------------------------------------------------------------
module dsst_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  dsst_pkg::cmd_type                   cmd,
   output dsst_pkg::sts_type                   sts,
   input  logic [dsst_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [dsst_pkg::SEQ_BITS-1:0]       req_seqnum,
   input  logic                                csr_write_enable,
   input  logic [dsst_pkg::LIMIT_BITS-1:0]     csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dsst_pkg::SEQ_BITS-1:0]       rsp_out_seqnum,
   output logic                                rsp_enforce_flag,
   output logic                                rsp_send_compressed,
   output logic                                rsp_recovered,
   output logic                                rsp_accepted,
   output logic                                rsp_resync_pending
);
   import dsst_pkg::*;

   // Latched word
   action_type          act_ff, act_in;
   logic [SEQ_BITS-1:0] seq_ff, seq_in;

   // Sender and receiver state
   logic [SEQ_BITS-1:0]     next_seqnum_ff, next_seqnum_in;
   logic                    prev_valid_ff, prev_valid_in;
   logic                    enforce_ff, enforce_in;
   logic [SEQ_BITS-1:0]     tracked_ff, tracked_in;
   logic [SEQ_BITS-1:0]     resync_ff, resync_in;
   logic                    waiting_ff, waiting_in;
   logic [LIMIT_BITS-1:0]   limit_ff, limit_in;
   logic [SEQ_BITS-1:0]     win_seq_ff [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] win_valid_ff, win_valid_in;
   logic [SEQ_BITS-1:0]     max_ff, max_in;

   // Pending result
   logic [SEQ_BITS-1:0] res_seq_ff, res_seq_in;
   logic                res_enf_ff, res_enf_in;
   logic                res_comp_ff, res_comp_in;
   logic                res_rec_ff, res_rec_in;
   logic                res_acc_ff, res_acc_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SEQ_BITS-1:0] rsp_seq_ff, rsp_seq_in;
   logic                rsp_enf_ff, rsp_enf_in;
   logic                rsp_comp_ff, rsp_comp_in;
   logic                rsp_rec_ff, rsp_rec_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic                rsp_wait_ff, rsp_wait_in;

   // Window lookups
   logic [CNT_BITS-1:0]     cnt_c;
   logic [CMP_BITS-1:0]     limit_c;
   logic [WINDOW_DEPTH-1:0] free_vec, free_first;
   logic [WINDOW_DEPTH-1:0] hit_vec, hit_first;
   logic [WINDOW_DEPTH-1:0] stale_vec;
   logic [SEQ_BITS-1:0]     want_c;
   logic [SEQ_BITS-1:0]     scan_val;
   logic                    scan_hit;
   logic                    room_c;
   logic                    write_slot;

   always_comb begin
      cnt_c = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         cnt_c = cnt_c + CNT_BITS'(win_valid_ff[i]);
      end
   end

   assign limit_c = (CMP_BITS'(limit_ff) > CMP_BITS'(WINDOW_DEPTH)) ?
                    CMP_BITS'(WINDOW_DEPTH) : CMP_BITS'(limit_ff);
   assign free_vec   = ~win_valid_ff;
   assign free_first = free_vec & (~free_vec + WINDOW_DEPTH'(1));
   assign room_c     = (CMP_BITS'(cnt_c) < limit_c) && (|free_vec);
   assign want_c     = seq_inc(tracked_ff);

   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         // a saturated tracked number never advances
         hit_vec[i]   = win_valid_ff[i] && (win_seq_ff[i] == want_c) &&
                        (tracked_ff != {SEQ_BITS{1'b1}});
         stale_vec[i] = win_valid_ff[i] && (win_seq_ff[i] <= seq_ff);
      end
   end

   assign hit_first = hit_vec & (~hit_vec + WINDOW_DEPTH'(1));
   assign scan_val  = win_seq_ff[cmd.scan_idx];
   assign scan_hit  = win_valid_ff[cmd.scan_idx] && (scan_val > max_ff);
   assign write_slot = cmd.exec && (act_ff == ACT_RECV_COMPRESSED) && room_c;

   always_comb begin
      act_in         = act_ff;
      seq_in         = seq_ff;
      next_seqnum_in = next_seqnum_ff;
      prev_valid_in  = prev_valid_ff;
      enforce_in     = enforce_ff;
      tracked_in     = tracked_ff;
      resync_in      = resync_ff;
      waiting_in     = waiting_ff;
      limit_in       = limit_ff;
      win_valid_in   = win_valid_ff;
      max_in         = max_ff;
      res_seq_in     = res_seq_ff;
      res_enf_in     = res_enf_ff;
      res_comp_in    = res_comp_ff;
      res_rec_in     = res_rec_ff;
      res_acc_in     = res_acc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_enf_in     = rsp_enf_ff;
      rsp_comp_in    = rsp_comp_ff;
      rsp_rec_in     = rsp_rec_ff;
      rsp_acc_in     = rsp_acc_ff;
      rsp_wait_in    = rsp_wait_ff;

      if (csr_write_enable) begin
         limit_in = csr_write_data;
      end

      if (cmd.load) begin
         act_in = action_type'(req_action);
         seq_in = req_seqnum;
      end

      if (cmd.exec) begin
         res_enf_in  = 1'b0;
         res_comp_in = 1'b0;
         res_rec_in  = 1'b0;
         res_acc_in  = 1'b0;
         max_in      = '0;
         case (act_ff)
            ACT_ISSUE: begin
               res_seq_in     = next_seqnum_ff;
               res_enf_in     = enforce_ff;
               res_comp_in    = prev_valid_ff;
               next_seqnum_in = seq_inc(next_seqnum_ff);
               enforce_in     = 1'b0;
               prev_valid_in  = 1'b1;
            end
            ACT_FORCE_COMPLETE: prev_valid_in = 1'b0;
            ACT_RECV_COMPLETE: begin
               tracked_in   = seq_ff;
               win_valid_in = win_valid_ff & ~stale_vec;
            end
            ACT_RECV_COMPRESSED: begin
               if (room_c) begin
                  win_valid_in = win_valid_ff | free_first;
                  res_acc_in   = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (cmd.chain) begin
         if (|hit_vec) begin
            win_valid_in = win_valid_ff & ~hit_first;
            tracked_in   = want_c;
            res_rec_in   = 1'b1;
         end else if (waiting_ff && (tracked_ff > resync_ff)) begin
            enforce_in = 1'b0;
            resync_in  = '0;
            waiting_in = 1'b0;
         end
      end

      if (cmd.scan && scan_hit) begin
         max_in = scan_val;
      end

      if (cmd.resync) begin
         resync_in  = (seq_ff >= max_ff) ? seq_ff : max_ff;
         waiting_in = 1'b1;
         enforce_in = 1'b1;
      end

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_seq_in   = (act_ff == ACT_ISSUE) ? res_seq_ff : tracked_ff;
         rsp_enf_in   = res_enf_ff;
         rsp_comp_in  = res_comp_ff;
         rsp_rec_in   = res_rec_ff;
         rsp_acc_in   = res_acc_ff;
         rsp_wait_in  = waiting_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seqnum_ff <= '0;
         prev_valid_ff  <= 1'b0;
         enforce_ff     <= 1'b0;
         tracked_ff     <= '0;
         resync_ff      <= '0;
         waiting_ff     <= 1'b0;
         limit_ff       <= LIMIT_RESET;
         win_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         next_seqnum_ff <= next_seqnum_in;
         prev_valid_ff  <= prev_valid_in;
         enforce_ff     <= enforce_in;
         tracked_ff     <= tracked_in;
         resync_ff      <= resync_in;
         waiting_ff     <= waiting_in;
         limit_ff       <= limit_in;
         win_valid_ff   <= win_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      seq_ff      <= seq_in;
      max_ff      <= max_in;
      res_seq_ff  <= res_seq_in;
      res_enf_ff  <= res_enf_in;
      res_comp_ff <= res_comp_in;
      res_rec_ff  <= res_rec_in;
      res_acc_ff  <= res_acc_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_enf_ff  <= rsp_enf_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_wait_ff <= rsp_wait_in;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (write_slot && free_first[i]) begin
            win_seq_ff[i] <= seq_ff;
         end
      end
   end

   assign sts.action      = act_ff;
   assign sts.room        = room_c;
   assign sts.waiting     = waiting_ff;
   assign sts.chain_found = |hit_vec;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_seqnum      = rsp_seq_ff;
   assign rsp_enforce_flag    = rsp_enf_ff;
   assign rsp_send_compressed = rsp_comp_ff;
   assign rsp_recovered       = rsp_rec_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_resync_pending  = rsp_wait_ff;

endmodule

/* hdl/delta_sync_sequence_tracker_core.sv */
`timescale 1ns / 1ps
// Steps: issue, force complete and a compressed word that is accepted or finds a
//   resync pending are latched, executed and published; receive complete also
//   chains k buffered entries (at most WINDOW_DEPTH); any other compressed word
//   scans the window for its max, one window entry per cycle, then sets resync.
// Throughput: one word at a time, next accepted in the cycle after the result is loaded.
// Reset: synchronous, active high; clears counters, flags, window valid bits, limit 16.
// ----------------------------------------------------------------------------
// delta_sync_sequence_tracker_core: sequence tracker for delta state sync
// Controller and datapath for sender numbering and receiver reorder window.
// ----------------------------------------------------------------------------
module delta_sync_sequence_tracker_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dsst_pkg::ACTION_BITS-1:0]  req_action,
   input  logic [dsst_pkg::SEQ_BITS-1:0]     req_seqnum,
   // window limit register
   input  logic                              csr_write_enable,
   input  logic [dsst_pkg::LIMIT_BITS-1:0]   csr_write_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dsst_pkg::SEQ_BITS-1:0]     rsp_out_seqnum,
   output logic                              rsp_enforce_flag,
   output logic                              rsp_send_compressed,
   output logic                              rsp_recovered,
   output logic                              rsp_accepted,
   output logic                              rsp_resync_pending
);
   import dsst_pkg::*;

   // Commands flow from the controller, status flows back. The datapath owns
   // every architectural register and the output word register, so a finished
   // word may sit on the response side while the controller takes the next one.
   cmd_type cmd;
   sts_type sts;

   // Sequence one word: latch, execute, then chain (complete), or scan the
   // window for its highest entry and set resync (compressed, window full, no
   // resync pending), and finally hand the result to the output register once free.
   dsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the sender counter, the receiver window and the resync point; the
   // window is compared in parallel for stale drops and the next chain link.
   dsst_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_action),
      .req_seqnum          (req_seqnum),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_seqnum      (rsp_out_seqnum),
      .rsp_enforce_flag    (rsp_enforce_flag),
      .rsp_send_compressed (rsp_send_compressed),
      .rsp_recovered       (rsp_recovered),
      .rsp_accepted        (rsp_accepted),
      .rsp_resync_pending  (rsp_resync_pending)
   );

endmodule

/* hdl/dsst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_checker: port-level checks of the sequence tracker
// Tracks words in flight and checks result flag exclusivity.
// ----------------------------------------------------------------------------
module dsst_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [dsst_pkg::SEQ_BITS-1:0]  rsp_out_seqnum,
   input logic                           rsp_enforce_flag,
   input logic                           rsp_send_compressed,
   input logic                           rsp_recovered,
   input logic                           rsp_accepted
);

   logic [1:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + 2'(req_take) - 2'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_seqnum))
      else $error("stalled response word changed");

   // no response without a word in flight
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> pending_ff != 2'd0)
      else $error("response without request");

   // a new word only enters with the work stage empty
   a_req_room: assert property (@(posedge clock) disable iff (reset)
      req_take |-> pending_ff == 2'd0 || pending_ff == 2'd1)
      else $error("request accepted with two words in flight");

   // issue, recover and accept results never mix
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_enforce_flag | rsp_send_compressed,
                              rsp_recovered, rsp_accepted}))
      else $error("result flags of different actions set together");

endmodule

bind delta_sync_sequence_tracker_core dsst_checker u_dsst_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_seqnum      (rsp_out_seqnum),
   .rsp_enforce_flag    (rsp_enforce_flag),
   .rsp_send_compressed (rsp_send_compressed),
   .rsp_recovered       (rsp_recovered),
   .rsp_accepted        (rsp_accepted)
);

/* tb/dsst_response_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_response_checker: response predictor and comparator
// Mirrors the tracker state for every request word accepted, queues the
// predicted response and compares each response word field by field.
// ----------------------------------------------------------------------------
module dsst_response_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [dsst_pkg::ACTION_BITS-1:0] req_action,
   input  logic [dsst_pkg::SEQ_BITS-1:0]    req_seqnum,
   input  logic                             csr_write_enable,
   input  logic [dsst_pkg::LIMIT_BITS-1:0]  csr_write_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [dsst_pkg::SEQ_BITS-1:0]    rsp_out_seqnum,
   input  logic                             rsp_enforce_flag,
   input  logic                             rsp_send_compressed,
   input  logic                             rsp_recovered,
   input  logic                             rsp_accepted,
   input  logic                             rsp_resync_pending,
   output int                               fail_count,
   output int                               pending_count
);
   import dsst_pkg::*;

   typedef struct packed {
      logic [SEQ_BITS-1:0] seqnum;
      logic                enforce_flag;
      logic                send_compressed;
      logic                recovered;
      logic                accepted;
      logic                resync_pending;
   } tracker_rsp_type;

   // Mirrored tracker state
   logic [SEQ_BITS-1:0]   issue_seqnum;
   logic                  prev_held;
   logic                  enforce_due;
   logic [SEQ_BITS-1:0]   tracked_seqnum;
   logic [SEQ_BITS-1:0]   resync_point;
   logic                  resync_wait;
   logic [SEQ_BITS-1:0]   slot_seq  [WINDOW_DEPTH];
   logic                  slot_used [WINDOW_DEPTH];
   logic [LIMIT_BITS-1:0] window_limit;

   tracker_rsp_type awaited_rsp [$];
   int              mismatches = 0;

   function automatic logic [SEQ_BITS-1:0] sat_next(input logic [SEQ_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Apply one request word to the mirrored state and return its response.
   function automatic tracker_rsp_type track_word(input action_type act,
                                                  input logic [SEQ_BITS-1:0] seq);
      tracker_rsp_type     r;
      logic                found;
      logic [SEQ_BITS-1:0] want;
      logic [SEQ_BITS-1:0] top_seq;
      int                  used_cnt;
      int                  cap;
      int                  free_slot;
      int                  i;
      r = '0;
      case (act)
         ACT_ISSUE: begin
            r.seqnum          = issue_seqnum;
            r.enforce_flag    = enforce_due;
            r.send_compressed = prev_held;
            issue_seqnum      = sat_next(issue_seqnum);
            enforce_due       = 1'b0;
            prev_held         = 1'b1;
         end
         ACT_FORCE_COMPLETE: begin
            prev_held = 1'b0;
         end
         ACT_RECV_COMPLETE: begin
            tracked_seqnum = seq;
            for (i = 0; i < WINDOW_DEPTH; i++)
               if (slot_used[i] && slot_seq[i] <= tracked_seqnum) slot_used[i] = 1'b0;
            found = 1'b1;
            while (found) begin
               found = 1'b0;
               want  = sat_next(tracked_seqnum);
               if (want != tracked_seqnum) begin
                  for (i = 0; i < WINDOW_DEPTH; i++) begin
                     if (!found && slot_used[i] && slot_seq[i] == want) begin
                        slot_used[i]   = 1'b0;
                        tracked_seqnum = want;
                        r.recovered    = 1'b1;
                        found          = 1'b1;
                     end
                  end
               end
            end
            if (resync_wait && tracked_seqnum > resync_point) begin
               enforce_due  = 1'b0;
               resync_point = '0;
               resync_wait  = 1'b0;
            end
         end
         default: begin
            cap       = (window_limit > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(window_limit);
            used_cnt  = 0;
            top_seq   = '0;
            free_slot = -1;
            for (i = 0; i < WINDOW_DEPTH; i++) begin
               if (slot_used[i]) begin
                  used_cnt++;
                  if (slot_seq[i] > top_seq) top_seq = slot_seq[i];
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (used_cnt < cap && free_slot >= 0) begin
               slot_seq[free_slot]  = seq;
               slot_used[free_slot] = 1'b1;
               r.accepted           = 1'b1;
            end else if (!resync_wait) begin
               resync_point = (seq >= top_seq) ? seq : top_seq;
               resync_wait  = 1'b1;
               enforce_due  = 1'b1;
            end
         end
      endcase
      if (act != ACT_ISSUE) r.seqnum = tracked_seqnum;
      r.resync_pending = resync_wait;
      return r;
   endfunction

   function automatic int field_mismatch(input string name,
                                         input logic [SEQ_BITS-1:0] want,
                                         input logic [SEQ_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      tracker_rsp_type want;
      if (reset) begin
         issue_seqnum   = '0;
         prev_held      = 1'b0;
         enforce_due    = 1'b0;
         tracked_seqnum = '0;
         resync_point   = '0;
         resync_wait    = 1'b0;
         window_limit   = LIMIT_RESET;
         for (int i = 0; i < WINDOW_DEPTH; i++) slot_used[i] = 1'b0;
         awaited_rsp.delete();
      end else begin
         // compare the response word first, then take the new request word
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t ns: response word with none expected, got out_seqnum 0x%0h",
                        $time, rsp_out_seqnum);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               mismatches += field_mismatch("out_seqnum", want.seqnum, rsp_out_seqnum);
               mismatches += field_mismatch("enforce_flag", want.enforce_flag,
                                            rsp_enforce_flag);
               mismatches += field_mismatch("send_compressed", want.send_compressed,
                                            rsp_send_compressed);
               mismatches += field_mismatch("recovered", want.recovered, rsp_recovered);
               mismatches += field_mismatch("accepted", want.accepted, rsp_accepted);
               mismatches += field_mismatch("resync_pending", want.resync_pending,
                                            rsp_resync_pending);
            end
         end
         if (csr_write_enable) window_limit = csr_write_data;
         if (req_valid && !req_stall) begin
            want = track_word(action_type'(req_action), req_seqnum);
            awaited_rsp.insert(awaited_rsp.size(), want);
         end
      end
      fail_count    <= mismatches;
      pending_count <= awaited_rsp.size();
   end

endmodule

/* tb/delta_sync_sequence_tracker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_sync_sequence_tracker_core_tb: top level of the tracker testbench
// Drives request words and window limit writes, stalls the response side,
// and gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module delta_sync_sequence_tracker_core_tb;
   import dsst_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 64;
   localparam int HOLD_PHASE   = 2;
   localparam int RANDOM_PHASE = 7;
   localparam int LONG_HOLD    = 250;
   localparam int DRAIN_CYCLES = 40;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [ACTION_BITS-1:0] req_action      = ACT_ISSUE;
   logic [SEQ_BITS-1:0]   req_seqnum       = '0;
   logic                  csr_write_enable = 1'b0;
   logic [LIMIT_BITS-1:0] csr_write_data   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [SEQ_BITS-1:0]   rsp_out_seqnum;
   logic                  rsp_enforce_flag;
   logic                  rsp_send_compressed;
   logic                  rsp_recovered;
   logic                  rsp_accepted;
   logic                  rsp_resync_pending;

   int fail_count;
   int pending_count;
   int cycle_count    = 0;
   int words_sent     = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;

   delta_sync_sequence_tracker_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_seqnum          (req_seqnum),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_seqnum      (rsp_out_seqnum),
      .rsp_enforce_flag    (rsp_enforce_flag),
      .rsp_send_compressed (rsp_send_compressed),
      .rsp_recovered       (rsp_recovered),
      .rsp_accepted        (rsp_accepted),
      .rsp_resync_pending  (rsp_resync_pending)
   );

   dsst_response_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_seqnum          (req_seqnum),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_seqnum      (rsp_out_seqnum),
      .rsp_enforce_flag    (rsp_enforce_flag),
      .rsp_send_compressed (rsp_send_compressed),
      .rsp_recovered       (rsp_recovered),
      .rsp_accepted        (rsp_accepted),
      .rsp_resync_pending  (rsp_resync_pending),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: give up on a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: stall in random bursts, and serve a long hold when the
   // stimulus asks for one so that the block backs up and stalls its input.
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request word, maybe after an idle burst, and hold it until taken.
   // Valid stays high on return so that back-to-back words need no toggle.
   task automatic send_word(input action_type act, input logic [SEQ_BITS-1:0] seq);
      int gap;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_seqnum <= seq;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Drop valid and hold off until every expected response word has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Write the window limit while the block is idle.
   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One reorder episode: buffer a shuffled run of compressed words above a
   // base, with the odd gap and stray sender action, then complete at or near
   // the base so that the window chains through what it holds. Runs longer
   // than the window provoke a resync request.
   task automatic run_episode(input int cap);
      logic [SEQ_BITS-1:0] base;
      int                  order [20];
      int                  n;
      int                  k;
      int                  j;
      int                  tmp;
      int                  pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)      base = SEQ_BITS'($urandom_range(0, 2000));
      else if (pick < 7) base = '1 - SEQ_BITS'($urandom_range(0, 24));
      else               base = $urandom;
      n = $urandom_range(1, cap + 2);
      for (k = 0; k < n; k++) order[k] = k + 1;
      for (k = n - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 7) == 0)
            send_word($urandom_range(0, 1) ? ACT_ISSUE : ACT_FORCE_COMPLETE, $urandom);
         // skip the odd word to leave a hole in the chain
         if ($urandom_range(0, 9) != 0)
            send_word(ACT_RECV_COMPRESSED, base + SEQ_BITS'(order[k]));
      end
      if ($urandom_range(0, 3) == 0)
         send_word(ACT_RECV_COMPLETE, base + SEQ_BITS'($urandom_range(0, n + 3)));
      else
         send_word(ACT_RECV_COMPLETE, base);
      // noise: any action, any number
      if ($urandom_range(0, 3) == 0)
         send_word(action_type'($urandom_range(0, 3)), $urandom);
   endtask

   initial begin
      logic [LIMIT_BITS-1:0] lim;
      int                    cap;
      int                    p;
      int                    phase_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Sender numbering under the reset limit; the ignored number carries ones.
      send_word(ACT_ISSUE, '1);
      send_word(ACT_ISSUE, $urandom);
      send_word(ACT_FORCE_COMPLETE, '1);
      send_word(ACT_ISSUE, '0);
      // Out of order, with a duplicate, then a complete set below the run.
      send_word(ACT_RECV_COMPRESSED, 32'd6);
      send_word(ACT_RECV_COMPRESSED, 32'd5);
      send_word(ACT_RECV_COMPRESSED, 32'd5);
      send_word(ACT_RECV_COMPLETE, 32'd4);
      // Chain into the top of the number space, then saturate.
      send_word(ACT_RECV_COMPRESSED, '1);
      send_word(ACT_RECV_COMPLETE, '1 - 1'b1);
      send_word(ACT_RECV_COMPLETE, '1);
      send_word(ACT_RECV_COMPLETE, '0);

      // Zero limit: an empty window is already full, so the resync point is
      // the word's own number; a second overflow while waiting is dropped.
      write_limit(LIMIT_BITS'(0));
      send_word(ACT_RECV_COMPRESSED, 32'd100);
      send_word(ACT_RECV_COMPRESSED, 32'd200);
      send_word(ACT_ISSUE, $urandom);
      send_word(ACT_RECV_COMPLETE, 32'd50);
      send_word(ACT_RECV_COMPLETE, 32'd101);

      // Two-entry window: overflow resyncs at the highest buffered number,
      // and only a complete set past that point clears it.
      write_limit(LIMIT_BITS'(2));
      send_word(ACT_RECV_COMPRESSED, 32'd10);
      send_word(ACT_RECV_COMPRESSED, 32'd12);
      send_word(ACT_RECV_COMPRESSED, 32'd11);
      send_word(ACT_ISSUE, $urandom);
      send_word(ACT_RECV_COMPLETE, 32'd9);
      send_word(ACT_RECV_COMPLETE, 32'd11);
      send_word(ACT_RECV_COMPLETE, 32'd13);

      // Random phases, each under its own limit, extremes included.
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:            lim = '1;
            1:            lim = LIMIT_BITS'(1);
            2:            lim = LIMIT_BITS'(16);
            3:            lim = LIMIT_BITS'(0);
            4:            lim = LIMIT_BITS'(4);
            5:            lim = LIMIT_BITS'(17);
            6:            lim = LIMIT_BITS'(2);
            RANDOM_PHASE: lim = LIMIT_BITS'($urandom);
            8:            lim = LIMIT_BITS'(8);
            default:      lim = LIMIT_BITS'(16);
         endcase
         write_limit(lim);
         cap = (lim > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(lim);
         if (p == HOLD_PHASE) hold_requests <= hold_requests + 1;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            // no idling in the closing phase; otherwise idle in some episodes only
            if (p == PHASES - 1) begin
               sender_idles   = 1'b0;
               receiver_idles <= 1'b0;
            end else begin
               sender_idles   = ($urandom_range(0, 3) != 0);
               receiver_idles <= ($urandom_range(0, 3) != 0);
            end
            run_episode(cap);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* delta_sync_sequence_tracker_core.f */
hdl/dsst_pkg.sv
hdl/dsst_ctrl.sv
hdl/dsst_datapath.sv
hdl/delta_sync_sequence_tracker_core.sv
hdl/dsst_checker.sv
tb/dsst_response_checker.sv
tb/delta_sync_sequence_tracker_core_tb.sv
